[sv/fdws_pkg.sv]
`timescale 1ns / 1ps
package fdws_pkg;
  localparam int unsigned FULL_SCORE = 100;
  localparam int unsigned BLINK_RESET = 300;
  localparam int unsigned WINDOW_RESET = 60000;

  typedef enum logic [1:0] {
    CFG_BLINK  = 2'd0,
    CFG_WINDOW = 2'd1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_PUSH,
    ST_PRUNE_RD,
    ST_PRUNE,
    ST_SCORE_RD,
    ST_SCAN,
    ST_TAIL,
    ST_DIV,
    ST_OUT
  } state_t;
endpackage

[sv/focus_debounce_window_score.sv]
`timescale 1ns / 1ps
// steps: update, an optional push, a prune walk and a score walk over the N events in
// the ring (up to EVENT_DEPTH), then a tail step and the divider unless now <= window start
// throughput: one item at a time, the next one is taken the cycle after the result is
// loaded; two event walks (one memory read per cycle) and a TIME_BITS + 7 step restoring
// divider make up the work; loading waits only while the previous result is unread
// reset: synchronous active low; focused, empty ring, blink 300, window 60000
module focus_debounce_window_score import fdws_pkg::*; #(
  parameter int EVENT_DEPTH = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // stamp[31:0], eyes_focused, restart, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // focused, score[6:0], overflow, zero pad
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  localparam int AW = $clog2(EVENT_DEPTH);
  localparam int CW = $clog2(EVENT_DEPTH + 1);
  localparam int TW = TIME_BITS;
  localparam int DW = TW + 7;
  localparam int XW = (TW > 24) ? TW : 24;

  state_t st_r, st_nxt;
  logic [15:0] blink_r;
  logic [23:0] win_r;
  logic focus_r, pend_r, base_r, drop_r;
  logic [TW-1:0] pstart_r, sbegin_r, now_r, ws_r, cut_r, prev_r;
  logic sig_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic cur_r, inwin_r;
  logic [TW-1:0] ftime_r, dur_r;
  logic [DW-1:0] num_r, rem_r;
  logic [6:0] cyc_r;
  logic [15:0] out_r;
  logic ovalid_r;
  logic pkind_r, k1_r, k2_r;
  logic [TW-1:0] pt_r;

  logic [TW:0] mem [EVENT_DEPTH];
  logic [TW:0] rd_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [TW:0] wdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, h} + {1'b0, i};
    if (s >= (CW+1)'(EVENT_DEPTH)) s = s - (CW+1)'(EVENT_DEPTH);
    return s[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  logic [TW-1:0] stamp;
  assign stamp = TW'(in_tdata[31:0]);
  assign in_tready = (st_r == ST_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata = out_r;

  logic out_load;
  assign out_load = (st_r == ST_OUT) && (!ovalid_r || out_tready);

  logic full;
  assign full = (cnt_r == CW'(EVENT_DEPTH));
  logic push_go;
  logic push_kind;
  logic [TW-1:0] push_t;
  logic [TW-1:0] elapsed;
  assign elapsed = (now_r >= pstart_r) ? now_r - pstart_r : '0;

  logic [XW-1:0] now_x, win_x;
  assign now_x = XW'(now_r);
  assign win_x = XW'(win_r);

  logic [TW-1:0] ws_c;
  assign ws_c = (cut_r > sbegin_r) ? cut_r : sbegin_r;

  logic below, prune_end;
  logic [CW-1:0] prune_k;
  assign below = rd_r[TW-1:0] < cut_r;
  assign prune_end = !below || (idx_r >= cnt_r);
  assign prune_k = below ? idx_r : idx_r - CW'(1);

  always_comb begin
    push_go = 1'b0; push_kind = 1'b0; push_t = now_r;
    if (sig_r) begin
      if (!focus_r) begin push_go = 1'b1; push_kind = 1'b1; end
    end else if (focus_r && pend_r && elapsed >= TW'(blink_r)) begin
      push_go = 1'b1; push_t = pstart_r;
    end
  end

  always_comb begin
    we = (st_r == ST_PUSH);
    waddr = slot(head_r, cnt_r);
    wdata = {pkind_r, pt_r};
    raddr = slot(head_r, idx_r);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (in_tvalid && in_tready) st_nxt = ST_UPDATE;
      ST_UPDATE:   st_nxt = push_go ? ST_PUSH : ST_PRUNE_RD;
      ST_PUSH:     st_nxt = ST_PRUNE_RD;
      ST_PRUNE_RD: st_nxt = (cnt_r == '0) ? ST_SCORE_RD : ST_PRUNE;
      ST_PRUNE:    st_nxt = prune_end ? ST_SCORE_RD : ST_PRUNE;
      ST_SCORE_RD: st_nxt = (now_r <= ws_c) ? ST_OUT :
                            ((cnt_r == '0) ? ST_TAIL : ST_SCAN);
      ST_SCAN:     st_nxt = (idx_r >= cnt_r) ? ST_TAIL : ST_SCAN;
      ST_TAIL:     st_nxt = ST_DIV;
      ST_DIV:      st_nxt = (cyc_r == 7'(DW - 1)) ? ST_OUT : ST_DIV;
      ST_OUT:      st_nxt = out_load ? ST_IDLE : ST_OUT;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  logic [TW-1:0] tclip;
  logic [DW:0] rsh;
  always_comb begin
    tclip = rd_r[TW-1:0];
    if (tclip < prev_r) tclip = prev_r;
    if (tclip > now_r) tclip = now_r;
    rsh = {rem_r, num_r[DW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; blink_r <= 16'(BLINK_RESET); win_r <= 24'(WINDOW_RESET);
      focus_r <= 1'b1; pend_r <= 1'b0; base_r <= 1'b1; sbegin_r <= '0;
      pstart_r <= '0; head_r <= '0; cnt_r <= '0; ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_BLINK)) blink_r <= cfg_wdata[15:0];
        else win_r <= cfg_wdata;
      end
      if (out_load) ovalid_r <= 1'b1;
      else if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      case (st_r)
        ST_IDLE: if (in_tvalid && in_tready) begin
          now_r <= stamp; sig_r <= in_tdata[32]; drop_r <= 1'b0; idx_r <= '0;
          if (in_tdata[33]) begin
            focus_r <= 1'b1; pend_r <= 1'b0; pstart_r <= '0; sbegin_r <= stamp;
            base_r <= 1'b1; head_r <= '0; cnt_r <= '0;
          end
        end
        ST_UPDATE: begin
          cut_r <= (now_x >= win_x) ? TW'(now_x - win_x) : '0;
          idx_r <= '0;
          pkind_r <= push_kind; pt_r <= push_t;
          if (sig_r) begin
            pend_r <= 1'b0;
            if (!focus_r) focus_r <= 1'b1;
          end else if (focus_r) begin
            if (!pend_r) begin pend_r <= 1'b1; pstart_r <= now_r; end
            else if (push_go) begin focus_r <= 1'b0; pend_r <= 1'b0; end
          end
        end
        ST_PUSH: begin
          if (full) begin
            base_r <= rd_r[TW]; head_r <= slot(head_r, CW'(1)); drop_r <= 1'b1;
          end else cnt_r <= cnt_r + CW'(1);
        end
        ST_PRUNE_RD: idx_r <= CW'(1);
        ST_PRUNE: begin
          if (prune_end) begin
            // keep the last event before the cutoff
            if (prune_k > CW'(1)) begin
              head_r <= slot(head_r, prune_k - CW'(1));
              cnt_r <= cnt_r - (prune_k - CW'(1));
              base_r <= below ? k1_r : k2_r;
            end
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
          k1_r <= rd_r[TW];
          k2_r <= k1_r;
        end
        ST_SCORE_RD: begin
          prev_r <= ws_c;
          ws_r <= ws_c;
          cur_r <= base_r; ftime_r <= '0; inwin_r <= 1'b0; idx_r <= CW'(1);
        end
        ST_SCAN: begin
          idx_r <= idx_r + CW'(1);
          if (rd_r[TW-1:0] < ws_r) begin
            if (!inwin_r) cur_r <= rd_r[TW];
          end else begin
            inwin_r <= 1'b1;
            if (cur_r) ftime_r <= ftime_r + (tclip - prev_r);
            cur_r <= rd_r[TW]; prev_r <= tclip;
          end
        end
        ST_TAIL: begin
          num_r <= DW'(cur_r ? ftime_r + (now_r - prev_r) : ftime_r) * DW'(FULL_SCORE);
          dur_r <= now_r - ws_r; rem_r <= '0; cyc_r <= '0;
        end
        ST_DIV: begin
          cyc_r <= cyc_r + 7'd1;
          num_r <= {num_r[DW-2:0], (rsh >= (DW+1)'(dur_r))};
          rem_r <= (rsh >= (DW+1)'(dur_r)) ? DW'(rsh - (DW+1)'(dur_r)) : DW'(rsh);
        end
        ST_OUT: begin
          if (out_load)
            out_r <= {7'd0, drop_r, (now_r <= ws_r) ? 7'(FULL_SCORE) : num_r[6:0], focus_r};
        end
        default: ;
      endcase
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CW'(EVENT_DEPTH))
    else $error("ring count over depth");
  a_out: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_OUT |=> out_tvalid) else $error("result not presented");
  a_score: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:1] <= 7'(FULL_SCORE)) else $error("score above full");
endmodule
